// ===== rtl/core/pvts_pkg.sv =====
`timescale 1ns / 1ps

package pvts_pkg;

    // Sequencer phases
    localparam logic [1:0] PH_NOISE = 2'd0;
    localparam logic [1:0] PH_MOTOR = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    // Report kinds
    localparam logic KIND_NOISE = 1'b0;
    localparam logic KIND_MOTOR = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO    = 2'd2;

    // Configuration reset values
    localparam logic [6:0]  RST_MOTOR_ON = 7'd50;
    localparam logic [15:0] RST_PERIOD   = 16'd1000;
    localparam logic [15:0] RST_RATIO    = 16'hFFFF;

    // Tick counter saturates here
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    // Variance result width and ceiling
    localparam int VAR_W = 37;
    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef logic signed [15:0] sample_t;
    typedef logic [VAR_W-1:0] var_t;

    // Configuration register set
    typedef struct packed {
        logic [6:0]  motor_on_ticks;
        logic [15:0] test_period_ticks;
        logic [15:0] test_ratio;
    } cfg_t;

    // Classified work item handed from front to back
    typedef struct packed {
        sample_t     acc_x;
        sample_t     acc_y;
        sample_t     acc_z;
        logic        accum;
        logic        report;
        logic        kind;
        logic        clear;
        logic        cmd_valid;
        logic [1:0]  motor_select;
        logic [15:0] motor_ratio;
        logic        done;
    } entry_t;

    // Front status
    typedef struct packed {
        logic [1:0] phase;
    } status_t;

endpackage

// ===== rtl/core/pvts_intf.sv =====
`timescale 1ns / 1ps

// Sample channel
interface pvts_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   acc_x;
    logic signed [15:0]   acc_y;
    logic signed [15:0]   acc_z;

    modport source (output valid, output acc_x, output acc_y, output acc_z, input ready);
    modport sink   (input valid, input acc_x, input acc_y, input acc_z, output ready);
endinterface

// Result channel
interface pvts_out_if;
    logic        valid;
    logic        ready;
    logic        motor_cmd_valid;
    logic [1:0]  motor_select;
    logic [15:0] motor_ratio;
    logic        report_valid;
    logic        report_kind;
    logic [36:0] var_x;
    logic [36:0] var_y;
    logic [36:0] var_z;
    logic        test_done;

    modport source (output valid, output motor_cmd_valid, output motor_select,
                    output motor_ratio, output report_valid, output report_kind,
                    output var_x, output var_y, output var_z, output test_done,
                    input ready);
    modport sink   (input valid, input motor_cmd_valid, input motor_select,
                    input motor_ratio, input report_valid, input report_kind,
                    input var_x, input var_y, input var_z, input test_done,
                    output ready);
endinterface

// Configuration write channel
interface pvts_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/propeller_vibration_test_sequencer.sv =====
`timescale 1ns / 1ps

// Channel   Role    Payload
// in_ch     sink    acc_x, acc_y, acc_z (signed 16-bit samples)
// out_ch    source  motor command, variance report, test_done
// cfg_ch    sink    index (2 bits), data (16 bits); always ready
//
// The front accepts one sample transaction per cycle while its 4-entry queue has room.
// The back steps a sample through idle, accumulate and emit; a report also squares the
// running sum and divides it by WINDOW one 16-bit digit per cycle by reciprocal multiply.
// A result held in the output register does not stop the back from starting the next entry.
// Reset is asynchronous and active low; it restores the configuration defaults.

module propeller_vibration_test_sequencer #(
    parameter int WINDOW      = 100,
    parameter int MOTOR_COUNT = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    pvts_in_if.sink      in_ch,
    pvts_out_if.source   out_ch,
    pvts_cfg_if.sink     cfg_ch
);

    pvts_pkg::cfg_t     cfg_reg;
    pvts_pkg::entry_t   push_entry;
    pvts_pkg::entry_t   head_entry;
    pvts_pkg::status_t  front_status;
    logic               push;
    logic               pop;
    logic               not_empty;
    logic               full;

    assign cfg_ch.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_on_ticks    <= pvts_pkg::RST_MOTOR_ON;
            cfg_reg.test_period_ticks <= pvts_pkg::RST_PERIOD;
            cfg_reg.test_ratio        <= pvts_pkg::RST_RATIO;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                pvts_pkg::CFG_MOTOR_ON: cfg_reg.motor_on_ticks    <= cfg_ch.data[6:0];
                pvts_pkg::CFG_PERIOD:   cfg_reg.test_period_ticks <= cfg_ch.data;
                pvts_pkg::CFG_RATIO:    cfg_reg.test_ratio        <= cfg_ch.data;
                default:                cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Classification of incoming samples
    pvts_front #(
        .WINDOW      (WINDOW),
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg_reg),
        .full   (full),
        .push   (push),
        .entry  (push_entry),
        .status (front_status)
    );

    // Decoupling queue
    pvts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_entry  (push_entry),
        .pop       (pop),
        .rd_entry  (head_entry),
        .not_empty (not_empty),
        .full      (full)
    );

    // Accumulation, variance and result delivery
    pvts_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_entry),
        .not_empty (not_empty),
        .pop       (pop),
        .out_ch    (out_ch)
    );

    // Once finished, the sequencer stays finished
    assert property (@(posedge clk) disable iff (!rst_n)
        front_status.phase == pvts_pkg::PH_DONE |=> front_status.phase == pvts_pkg::PH_DONE)
        else $error("sequencer left the finished phase");

    // Queuing the completion marker moves the front into the finished phase
    assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.done |=> front_status.phase == pvts_pkg::PH_DONE)
        else $error("completion queued without finishing the sequence");

    // A completion result carries neither a command nor a report
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.test_done |-> !out_ch.report_valid && !out_ch.motor_cmd_valid)
        else $error("completion result mixed with command or report");

    // Nothing is queued after the sequence has finished except inert entries
    assert property (@(posedge clk) disable iff (!rst_n)
        push && front_status.phase == pvts_pkg::PH_DONE
        |-> !push_entry.report && !push_entry.cmd_valid && !push_entry.done)
        else $error("active entry queued after completion");

endmodule

// ===== rtl/core/pvts_front.sv =====
`timescale 1ns / 1ps

module pvts_front #(
    parameter int WINDOW      = 100,
    parameter int MOTOR_COUNT = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    pvts_in_if.sink             in_ch,
    input  pvts_pkg::cfg_t      cfg,
    input  logic                full,
    output logic                push,
    output pvts_pkg::entry_t    entry,
    output pvts_pkg::status_t   status
);

    localparam logic [15:0] WIN16   = 16'(WINDOW);
    localparam logic [2:0]  MCOUNT3 = 3'(MOTOR_COUNT);

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [1:0]  motor_reg, motor_next;
    logic [15:0] tick_inc;
    logic [2:0]  motor_inc;

    assign in_ch.ready   = !full;
    assign push          = in_ch.valid && !full;
    assign status.phase  = phase_reg;
    assign motor_inc     = {1'b0, motor_reg} + 3'd1;

    // Classify the sample against the tick schedule
    always_comb
    begin
        phase_next         = phase_reg;
        tick_next          = tick_reg;
        motor_next         = motor_reg;
        tick_inc           = tick_reg;
        entry              = '0;
        entry.acc_x        = in_ch.acc_x;
        entry.acc_y        = in_ch.acc_y;
        entry.acc_z        = in_ch.acc_z;
        case (phase_reg)
            pvts_pkg::PH_NOISE:
            begin
                tick_inc    = tick_reg + 16'd1;
                entry.accum = 1'b1;
                if (tick_inc >= WIN16)
                begin
                    entry.report = 1'b1;
                    entry.kind   = pvts_pkg::KIND_NOISE;
                    entry.clear  = 1'b1;
                    tick_next    = '0;
                    phase_next   = pvts_pkg::PH_MOTOR;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            pvts_pkg::PH_MOTOR:
            begin
                entry.accum = (tick_reg < WIN16);
                tick_inc    = (tick_reg != pvts_pkg::TICK_MAX) ? tick_reg + 16'd1 : tick_reg;
                tick_next   = tick_inc;
                if (tick_inc == 16'd1)
                begin
                    entry.cmd_valid    = 1'b1;
                    entry.motor_select = motor_reg;
                    entry.motor_ratio  = cfg.test_ratio;
                end
                else if (tick_inc == {9'd0, cfg.motor_on_ticks})
                begin
                    entry.cmd_valid    = 1'b1;
                    entry.motor_select = motor_reg;
                end
                else if (tick_inc == WIN16)
                begin
                    entry.report       = 1'b1;
                    entry.kind         = pvts_pkg::KIND_MOTOR;
                    entry.motor_select = motor_reg;
                end
                else if (tick_inc >= cfg.test_period_ticks)
                begin
                    entry.clear = 1'b1;
                    tick_next   = '0;
                    if (motor_inc >= MCOUNT3)
                    begin
                        motor_next = '0;
                        phase_next = pvts_pkg::PH_DONE;
                        entry.done = 1'b1;
                    end
                    else
                    begin
                        motor_next = motor_inc[1:0];
                    end
                end
            end
            default:
            begin
                tick_next = tick_reg;
            end
        endcase
    end

    // Sequencer state advances on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pvts_pkg::PH_NOISE;
            tick_reg  <= '0;
            motor_reg <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            motor_reg <= motor_next;
        end
    end

endmodule

// ===== rtl/core/pvts_queue.sv =====
`timescale 1ns / 1ps

module pvts_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pvts_pkg::entry_t  wr_entry,
    input  logic              pop,
    output pvts_pkg::entry_t  rd_entry,
    output logic              not_empty,
    output logic              full
);

    localparam int DEPTH = pvts_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pvts_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign rd_entry  = slot_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/pvts_back.sv =====
`timescale 1ns / 1ps

module pvts_back #(
    parameter int WINDOW = 100
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pvts_pkg::entry_t  head,
    input  logic              not_empty,
    output logic              pop,
    pvts_out_if.source        out_ch
);

    localparam int SUMW = 16 + $clog2(WINDOW);
    localparam int SQW  = 31 + $clog2(WINDOW);
    localparam int PW   = 2 * SUMW;
    localparam int EW   = (PW > pvts_pkg::VAR_W) ? PW : pvts_pkg::VAR_W + 1;
    localparam int RMW  = $clog2(WINDOW);

    // The squared sum is padded to three 16-bit digits and divided one digit per step.
    localparam int DIVW = 48;
    localparam int NDIG = 3;
    localparam int TW   = RMW + 16;
    localparam int RCW  = TW + 1;
    localparam int PRW  = TW + RCW;
    localparam int KSH  = TW + RMW;

    // Rounded-up reciprocal of WINDOW, exact for every partial dividend below 2^TW.
    localparam logic [63:0]    RECIP64 = ((64'd1 << KSH) + 64'(WINDOW - 1)) / 64'(WINDOW);
    localparam logic [RCW-1:0] RECIP   = RCW'(RECIP64);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]              state_reg, state_next;
    pvts_pkg::entry_t        cur_reg;
    logic signed [15:0]      smp_reg   [3];
    logic [30:0]             sq_reg    [3];
    logic signed [SUMW-1:0]  sum_reg   [3];
    logic [SQW-1:0]          sumsq_reg [3];
    logic [SQW-1:0]          snap_reg  [3];
    logic [SUMW-1:0]         mag_reg   [3];
    logic [DIVW-1:0]         quo_reg   [3];
    logic [RMW-1:0]          rem_reg   [3];
    logic [1:0]              step_reg;
    pvts_pkg::var_t          var_reg   [3];

    logic signed [15:0]      head_smp  [3];
    logic signed [31:0]      head_sq   [3];
    logic signed [SUMW-1:0]  sum_eff   [3];
    logic [SQW-1:0]          sumsq_eff [3];
    logic [TW-1:0]           part      [3];
    logic [PRW-1:0]          prod      [3];
    logic [15:0]             digit     [3];
    logic [RMW-1:0]          rem_next  [3];
    logic [EW-1:0]           diff      [3];

    logic                    out_valid_reg;
    logic                    out_load;
    logic                    out_cmd_reg;
    logic [1:0]              out_sel_reg;
    logic [15:0]             out_ratio_reg;
    logic                    out_rep_reg;
    logic                    out_kind_reg;
    pvts_pkg::var_t          out_var_reg [3];
    logic                    out_done_reg;

    assign pop      = (state_reg == ST_IDLE) && not_empty;
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);

    assign head_smp[0] = head.acc_x;
    assign head_smp[1] = head.acc_y;
    assign head_smp[2] = head.acc_z;

    // Per-axis datapath: squares, running sums, one quotient digit by reciprocal multiply
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            head_sq[a]   = head_smp[a] * head_smp[a];
            sum_eff[a]   = cur_reg.accum ? sum_reg[a] + SUMW'(smp_reg[a]) : sum_reg[a];
            sumsq_eff[a] = cur_reg.accum ? sumsq_reg[a] + SQW'(sq_reg[a]) : sumsq_reg[a];
            part[a]      = {rem_reg[a], quo_reg[a][DIVW-1 -: 16]};
            prod[a]      = PRW'(part[a]) * PRW'(RECIP);
            digit[a]     = 16'(prod[a] >> KSH);
            rem_next[a]  = RMW'(part[a] - TW'(digit[a]) * TW'(WINDOW));
            diff[a]      = (EW'(snap_reg[a]) >= EW'(quo_reg[a]))
                           ? EW'(snap_reg[a]) - EW'(quo_reg[a]) : '0;
        end
    end

    // Sequencing of one queue entry
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = cur_reg.report ? ST_MUL : ST_EMIT;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == 2'(NDIG - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a]   <= '0;
                sumsq_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_ACC)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    sum_reg[a]   <= cur_reg.clear ? '0 : sum_eff[a];
                    sumsq_reg[a] <= cur_reg.clear ? '0 : sumsq_eff[a];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg <= head;
                for (int a = 0; a < 3; a++)
                begin
                    smp_reg[a] <= head_smp[a];
                    sq_reg[a]  <= head_sq[a][30:0];
                end
            end
            ST_ACC:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    snap_reg[a] <= sumsq_eff[a];
                    mag_reg[a]  <= (sum_eff[a] < 0) ? SUMW'(-sum_eff[a]) : SUMW'(sum_eff[a]);
                end
            end
            ST_MUL:
            begin
                step_reg <= '0;
                for (int a = 0; a < 3; a++)
                begin
                    quo_reg[a] <= DIVW'(PW'(mag_reg[a]) * PW'(mag_reg[a]));
                    rem_reg[a] <= '0;
                end
            end
            ST_DIV:
            begin
                step_reg <= step_reg + 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    rem_reg[a] <= rem_next[a];
                    quo_reg[a] <= {quo_reg[a][DIVW-17:0], digit[a]};
                end
            end
            ST_FIN:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    var_reg[a] <= (diff[a] > EW'(pvts_pkg::VAR_MAX))
                                  ? pvts_pkg::VAR_MAX : diff[a][pvts_pkg::VAR_W-1:0];
                end
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
        if (out_load)
        begin
            out_cmd_reg   <= cur_reg.cmd_valid;
            out_sel_reg   <= cur_reg.motor_select;
            out_ratio_reg <= cur_reg.motor_ratio;
            out_rep_reg   <= cur_reg.report;
            out_kind_reg  <= cur_reg.kind;
            out_done_reg  <= cur_reg.done;
            for (int a = 0; a < 3; a++)
            begin
                out_var_reg[a] <= cur_reg.report ? var_reg[a] : '0;
            end
        end
    end

    // Result channel
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.motor_cmd_valid = out_cmd_reg;
    assign out_ch.motor_select    = out_sel_reg;
    assign out_ch.motor_ratio     = out_ratio_reg;
    assign out_ch.report_valid    = out_rep_reg;
    assign out_ch.report_kind     = out_kind_reg;
    assign out_ch.var_x           = out_var_reg[0];
    assign out_ch.var_y           = out_var_reg[1];
    assign out_ch.var_z           = out_var_reg[2];
    assign out_ch.test_done       = out_done_reg;

endmodule

// ===== bench/propeller_vibration_test_sequencer_test.sv =====
`timescale 1ns / 1ps

module propeller_vibration_test_sequencer_test;

    localparam int WINDOW      = 100;
    localparam int MOTOR_COUNT = 4;

    // Index 3 addresses no register; a write there must change nothing.
    localparam logic [pvts_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Receiver stall patterns
    localparam int STALL_NONE  = 0;
    localparam int STALL_HALF  = 1;
    localparam int STALL_HEAVY = 2;

    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 120;
    localparam int MAX_PRINTED      = 30;

    typedef struct packed {
        pvts_pkg::sample_t x;
        pvts_pkg::sample_t y;
        pvts_pkg::sample_t z;
    } accel_sample_t;

    typedef struct packed {
        logic           cmd_valid;
        logic [1:0]     select;
        logic [15:0]    ratio;
        logic           report_valid;
        logic           report_kind;
        pvts_pkg::var_t var_x;
        pvts_pkg::var_t var_y;
        pvts_pkg::var_t var_z;
        logic           done;
    } sequencer_result_t;

    logic clk;
    logic rst_n;

    pvts_in_if  sample_ch ();
    pvts_out_if result_ch ();
    pvts_cfg_if cfg_ch ();

    propeller_vibration_test_sequencer #(
        .WINDOW      (WINDOW),
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (sample_ch),
        .out_ch (result_ch),
        .cfg_ch (cfg_ch)
    );

    accel_sample_t     pending_samples[$];
    sequencer_result_t expected_results[$];

    // Predictor state and its copy of the registers
    pvts_pkg::cfg_t    seq_cfg;
    logic [1:0]        seq_phase;
    int unsigned       tick_count;
    int unsigned       motor_index;
    longint            axis_sum[3];
    longint unsigned   axis_sumsq[3];

    bit in_fire = 1'b0;
    int samples_accepted = 0;
    int results_seen = 0;
    int reports_seen = 0;
    int commands_seen = 0;
    int done_seen = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int stall_mode = STALL_NONE;
    int stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predictor

    function automatic void clear_axes();
        for (int a = 0; a < 3; a++)
        begin
            axis_sum[a]   = 0;
            axis_sumsq[a] = 0;
        end
    endfunction

    function automatic void accumulate_axes(accel_sample_t smp);
        longint s[3];
        s[0] = smp.x;
        s[1] = smp.y;
        s[2] = smp.z;
        for (int a = 0; a < 3; a++)
        begin
            axis_sum[a]   += s[a];
            axis_sumsq[a] += longint'(s[a] * s[a]);
        end
    endfunction

    // Sum of squares less the floored squared sum over the window, clipped at the ceiling.
    function automatic pvts_pkg::var_t axis_variance(int a);
        longint unsigned m;
        longint unsigned q;
        longint unsigned v;
        m = (axis_sum[a] < 0) ? -axis_sum[a] : axis_sum[a];
        q = (m * m) / WINDOW;
        v = (axis_sumsq[a] >= q) ? axis_sumsq[a] - q : 0;
        if (v > pvts_pkg::VAR_MAX)
            return pvts_pkg::VAR_MAX;
        return v[pvts_pkg::VAR_W-1:0];
    endfunction

    function automatic void fill_variances(inout sequencer_result_t r, input logic kind);
        r.report_valid = 1'b1;
        r.report_kind  = kind;
        r.var_x        = axis_variance(0);
        r.var_y        = axis_variance(1);
        r.var_z        = axis_variance(2);
    endfunction

    function automatic sequencer_result_t advance_sequencer(accel_sample_t smp);
        sequencer_result_t r;
        r = '0;
        case (seq_phase)
            pvts_pkg::PH_NOISE:
            begin
                accumulate_axes(smp);
                tick_count++;
                if (tick_count >= WINDOW)
                begin
                    fill_variances(r, pvts_pkg::KIND_NOISE);
                    tick_count = 0;
                    clear_axes();
                    seq_phase = pvts_pkg::PH_MOTOR;
                end
            end
            pvts_pkg::PH_MOTOR:
            begin
                if (tick_count < WINDOW)
                    accumulate_axes(smp);
                if (tick_count < pvts_pkg::TICK_MAX)
                    tick_count++;
                // Only the first matching tick acts.
                if (tick_count == 1)
                begin
                    r.cmd_valid = 1'b1;
                    r.select    = motor_index[1:0];
                    r.ratio     = seq_cfg.test_ratio;
                end
                else if (tick_count == seq_cfg.motor_on_ticks)
                begin
                    r.cmd_valid = 1'b1;
                    r.select    = motor_index[1:0];
                end
                else if (tick_count == WINDOW)
                begin
                    fill_variances(r, pvts_pkg::KIND_MOTOR);
                    r.select = motor_index[1:0];
                end
                else if (tick_count >= seq_cfg.test_period_ticks)
                begin
                    tick_count = 0;
                    clear_axes();
                    motor_index++;
                    if (motor_index >= MOTOR_COUNT)
                    begin
                        motor_index = 0;
                        seq_phase   = pvts_pkg::PH_DONE;
                        r.done      = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Checking

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
    endtask

    // Sampling at the rising edge: predict on sample transactions, check result transactions.
    always @(posedge clk)
    begin
        sequencer_result_t got;
        sequencer_result_t want;
        bit out_fire;
        bit cfg_fire;
        if (rst_n)
        begin
            in_fire  = sample_ch.valid && sample_ch.ready;
            out_fire = result_ch.valid && result_ch.ready;
            cfg_fire = cfg_ch.valid && cfg_ch.ready;

            if (in_fire)
            begin
                expected_results.push_back(advance_sequencer(
                    '{sample_ch.acc_x, sample_ch.acc_y, sample_ch.acc_z}));
                samples_accepted++;
            end

            if (cfg_fire)
            begin
                case (cfg_ch.index)
                    pvts_pkg::CFG_MOTOR_ON: seq_cfg.motor_on_ticks    = cfg_ch.data[6:0];
                    pvts_pkg::CFG_PERIOD:   seq_cfg.test_period_ticks = cfg_ch.data;
                    pvts_pkg::CFG_RATIO:    seq_cfg.test_ratio        = cfg_ch.data;
                    default: ;
                endcase
            end

            if (out_fire)
            begin
                got = '{result_ch.motor_cmd_valid, result_ch.motor_select,
                        result_ch.motor_ratio, result_ch.report_valid,
                        result_ch.report_kind, result_ch.var_x, result_ch.var_y,
                        result_ch.var_z, result_ch.test_done};
                if (expected_results.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("motor_cmd_valid", got.cmd_valid, want.cmd_valid);
                    check_field("motor_select", got.select, want.select);
                    check_field("motor_ratio", got.ratio, want.ratio);
                    check_field("report_valid", got.report_valid, want.report_valid);
                    check_field("report_kind", got.report_kind, want.report_kind);
                    check_field("var_x", got.var_x, want.var_x);
                    check_field("var_y", got.var_y, want.var_y);
                    check_field("var_z", got.var_z, want.var_z);
                    check_field("test_done", got.done, want.done);
                end
                results_seen++;
                reports_seen  += got.report_valid;
                commands_seen += got.cmd_valid;
                done_seen     += got.done;
            end

            // Watchdog on cycles with no transaction anywhere
            if (in_fire || out_fire || cfg_fire)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Sample driver: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                void'(pending_samples.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            // A transaction on offer stays as it is until taken.
            if (!(sample_ch.valid && !in_fire))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    burst_left = $urandom_range(1, 24);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.acc_x <= pending_samples[0].x;
                    sample_ch.acc_y <= pending_samples[0].y;
                    sample_ch.acc_z <= pending_samples[0].z;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: changing stall patterns, and one long hold-off so the block backs up.
    always @(negedge clk)
    begin
        if (!long_hold_done && samples_accepted >= LONG_HOLD_AT)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
                stall_left = $urandom_range(20, 80);
            end
            stall_left--;
            case (stall_mode)
                STALL_NONE: result_ch.ready <= 1'b1;
                STALL_HALF: result_ch.ready <= 1'($urandom_range(0, 1));
                default:    result_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Stimulus helpers

    task automatic queue_sample(input int x, input int y, input int z);
        pending_samples.push_back('{pvts_pkg::sample_t'(x), pvts_pkg::sample_t'(y),
                                    pvts_pkg::sample_t'(z)});
    endtask

    function automatic int random_axis();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 32767 : -32768;
            1:       return int'($urandom_range(0, 16)) - 8;
            default: return int'(pvts_pkg::sample_t'($urandom));
        endcase
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_sample(random_axis(), random_axis(), random_axis());
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [pvts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Test sequence
    initial
    begin
        rst_n           = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.acc_x = '0;
        sample_ch.acc_y = '0;
        sample_ch.acc_z = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;

        seq_cfg     = '{pvts_pkg::RST_MOTOR_ON, pvts_pkg::RST_PERIOD, pvts_pkg::RST_RATIO};
        seq_phase   = pvts_pkg::PH_NOISE;
        tick_count  = 0;
        motor_index = 0;
        clear_axes();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: noise floor opening with extreme samples, then motor 0
        // through its switch-off and its report.
        queue_sample(32767, 32767, 32767);
        queue_sample(-32768, -32768, -32768);
        queue_sample(0, 0, 0);
        queue_sample(-1, -1, -1);
        queue_sample(32767, -32768, 0);
        queue_sample(-32768, 0, 32767);
        queue_sample(0, 32767, -32768);
        queue_sample(21845, -21846, 1);
        queue_random(202);
        wait_idle();

        // A period of zero ends motor 0 on the next sample; an unused index is harmless.
        write_reg(pvts_pkg::CFG_PERIOD, 16'd0);
        write_reg(pvts_pkg::CFG_MOTOR_ON, 16'd0);
        write_reg(pvts_pkg::CFG_RATIO, 16'h0000);
        write_reg(CFG_UNUSED, 16'hFFFF);
        queue_random(1);
        wait_idle();

        // Motor 1: never switched off, a period of one advances on tick 2.
        write_reg(pvts_pkg::CFG_PERIOD, 16'd1);
        queue_random(2);
        wait_idle();

        // Motor 2: switched off on tick 2, a period equal to that advances on tick 3.
        write_reg(pvts_pkg::CFG_MOTOR_ON, 16'd2);
        write_reg(pvts_pkg::CFG_PERIOD, 16'd2);
        write_reg(pvts_pkg::CFG_RATIO, 16'hFFFF);
        queue_random(3);
        wait_idle();

        // Motor 3: high bits dropped leave a switch-off tick equal to the window,
        // which suppresses the report; samples run on past the window.
        write_reg(pvts_pkg::CFG_MOTOR_ON, 16'hFFE4);
        write_reg(pvts_pkg::CFG_PERIOD, 16'hFFFF);
        write_reg(pvts_pkg::CFG_RATIO, 16'($urandom));
        queue_random(140);
        wait_idle();

        // A period equal to the window ends the last motor and finishes the test.
        write_reg(pvts_pkg::CFG_MOTOR_ON, 16'd99);
        write_reg(pvts_pkg::CFG_PERIOD, 16'd100);
        queue_random(60);
        wait_idle();

        // Once finished, no setting brings the sequencer back.
        write_reg(pvts_pkg::CFG_MOTOR_ON, 16'd127);
        write_reg(pvts_pkg::CFG_PERIOD, 16'd101);
        write_reg(pvts_pkg::CFG_RATIO, 16'h0001);
        queue_random(100);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d sample transactions and %0d result transactions,",
                 samples_accepted, results_seen);
        $display("with %0d variance reports, %0d motor commands and %0d done pulses.",
                 reports_seen, commands_seen, done_seen);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== propeller_vibration_test_sequencer.f =====
rtl/core/pvts_pkg.sv
rtl/core/pvts_intf.sv
rtl/core/pvts_front.sv
rtl/core/pvts_queue.sv
rtl/core/pvts_back.sv
rtl/core/propeller_vibration_test_sequencer.sv
bench/propeller_vibration_test_sequencer_test.sv
